>>> src/bsfr_pkg.sv
// bsfr_pkg: types, register indexes, reset values and codes for the
// byte-stuffed frame receiver; used by every module of the block
`default_nettype none

package bsfr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int LEN_W       = 12;
    localparam int COUNT_W     = 13;
    localparam int PKT_W       = 16;
    localparam int CNT32_W     = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_BYTE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STUFF_MASK  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIPE_TYPE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PKTS_BLOCK  = 3'd6;

    localparam logic [7:0]       RST_START_BYTE  = 8'h7E;
    localparam logic [7:0]       RST_END_BYTE    = 8'h7D;
    localparam logic [7:0]       RST_ESCAPE_BYTE = 8'h7C;
    localparam logic [7:0]       RST_STUFF_MASK  = 8'h20;
    localparam logic [7:0]       RST_PIPE_TYPE   = 8'h00;
    localparam logic [LEN_W-1:0] RST_MAX_LENGTH  = 12'd1024;
    localparam logic [PKT_W-1:0] RST_PKTS_BLOCK  = 16'd16;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_TYPE     = 3'd1,
        MODE_MSG      = 3'd2,
        MODE_MSG_ESC  = 3'd3,
        MODE_PIPE     = 3'd4,
        MODE_PIPE_ESC = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0]       start_byte;
        logic [7:0]       end_byte;
        logic [7:0]       escape_byte;
        logic [7:0]       stuff_mask;
        logic [7:0]       pipe_type;
        logic [LEN_W-1:0] max_length;
        logic [PKT_W-1:0] packets_per_block;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic               is_pipe;
        logic [LEN_W-1:0]   frame_length;
        logic               block_done;
        logic [CNT32_W-1:0] dropped_total;
        logic [CNT32_W-1:0] good_messages;
    } result_t;

endpackage

`default_nettype wire

>>> src/bsfr_cfg.sv
// bsfr_cfg: configuration register file written through the plain write port
// depends on bsfr_pkg for register indexes, reset values and cfg_t
`default_nettype none

module bsfr_cfg
    import bsfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_BYTE:  cfg_next.start_byte        = cfg_data[7:0];
                CFG_END_BYTE:    cfg_next.end_byte          = cfg_data[7:0];
                CFG_ESCAPE_BYTE: cfg_next.escape_byte       = cfg_data[7:0];
                CFG_STUFF_MASK:  cfg_next.stuff_mask        = cfg_data[7:0];
                CFG_PIPE_TYPE:   cfg_next.pipe_type         = cfg_data[7:0];
                CFG_MAX_LENGTH:  cfg_next.max_length        = cfg_data[LEN_W-1:0];
                CFG_PKTS_BLOCK:  cfg_next.packets_per_block = cfg_data[PKT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte        <= RST_START_BYTE;
            cfg_reg.end_byte          <= RST_END_BYTE;
            cfg_reg.escape_byte       <= RST_ESCAPE_BYTE;
            cfg_reg.stuff_mask        <= RST_STUFF_MASK;
            cfg_reg.pipe_type         <= RST_PIPE_TYPE;
            cfg_reg.max_length        <= RST_MAX_LENGTH;
            cfg_reg.packets_per_block <= RST_PKTS_BLOCK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/bsfr_core.sv
// bsfr_core: deframing state machine, frame length and drop/message/block counters
// depends on bsfr_pkg for mode_t, kind_t, cfg_t and result_t
`default_nettype none

module bsfr_core
    import bsfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output logic            res_valid,
    output result_t         res
);

    mode_t              mode_reg, mode_next;
    logic               on_pipe_reg, on_pipe_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [PKT_W-1:0]   packets_reg, packets_next;
    logic [CNT32_W-1:0] drop_reg, drop_next;
    logic [CNT32_W-1:0] msg_reg, msg_next;

    logic [COUNT_W-1:0] count_inc;
    logic [PKT_W-1:0]   packets_inc;
    logic [7:0]         store_val;
    logic               do_store;
    logic               in_body;

    assign count_inc   = count_reg + COUNT_W'(1);
    assign packets_inc = packets_reg + PKT_W'(1);
    assign in_body     = (mode_reg == MODE_MSG) || (mode_reg == MODE_MSG_ESC) ||
                         (mode_reg == MODE_PIPE) || (mode_reg == MODE_PIPE_ESC);

    always_comb
    begin
        mode_next    = mode_reg;
        on_pipe_next = on_pipe_reg;
        count_next   = count_reg;
        packets_next = packets_reg;
        drop_next    = drop_reg;
        msg_next     = msg_reg;
        do_store     = 1'b0;
        store_val    = rx_byte;
        res_valid    = 1'b0;
        res.kind         = KIND_DATA;
        res.data         = 8'd0;
        res.frame_length = '0;
        res.block_done   = 1'b0;

        if (rx_byte == cfg.start_byte)
        begin
            // start flag restarts from any state, aborting a body in progress
            mode_next  = MODE_TYPE;
            count_next = '0;
            if (in_body)
            begin
                res_valid = 1'b1;
                res.kind  = KIND_ABORT;
            end
        end
        else
        begin
            unique case (mode_reg) inside
                MODE_TYPE:
                begin
                    on_pipe_next = (rx_byte == cfg.pipe_type);
                    mode_next    = on_pipe_next ? MODE_PIPE : MODE_MSG;
                    count_next   = COUNT_W'(1);
                    res_valid    = 1'b1;
                    res.data     = rx_byte;
                end
                MODE_MSG, MODE_PIPE:
                begin
                    if (rx_byte == cfg.escape_byte)
                    begin
                        mode_next = on_pipe_reg ? MODE_PIPE_ESC : MODE_MSG_ESC;
                    end
                    else if (rx_byte == cfg.end_byte)
                    begin
                        if (on_pipe_reg)
                        begin
                            if (packets_inc == cfg.packets_per_block)
                            begin
                                packets_next   = '0;
                                res.block_done = 1'b1;
                            end
                            else
                            begin
                                packets_next = packets_inc;
                            end
                        end
                        else
                        begin
                            msg_next = msg_reg + CNT32_W'(1);
                        end
                        mode_next        = MODE_IDLE;
                        count_next       = '0;
                        res_valid        = 1'b1;
                        res.kind         = KIND_GOOD;
                        res.frame_length = count_reg[LEN_W-1:0];
                    end
                    else
                    begin
                        do_store = 1'b1;
                    end
                end
                MODE_MSG_ESC, MODE_PIPE_ESC:
                begin
                    do_store  = 1'b1;
                    store_val = rx_byte ^ cfg.stuff_mask;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            if (do_store)
            begin
                res_valid = 1'b1;
                if (count_inc > {1'b0, cfg.max_length})
                begin
                    drop_next  = drop_reg + CNT32_W'(1);
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                    res.kind   = KIND_ABORT;
                end
                else
                begin
                    count_next = count_inc;
                    mode_next  = on_pipe_reg ? MODE_PIPE : MODE_MSG;
                    res.data   = store_val;
                end
            end
        end

        res.is_pipe       = on_pipe_next;
        res.dropped_total = drop_next;
        res.good_messages = msg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            on_pipe_reg <= 1'b0;
            count_reg   <= '0;
            packets_reg <= '0;
            drop_reg    <= '0;
            msg_reg     <= '0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            on_pipe_reg <= on_pipe_next;
            count_reg   <= count_next;
            packets_reg <= packets_next;
            drop_reg    <= drop_next;
            msg_reg     <= msg_next;
        end
    end

endmodule

`default_nettype wire

>>> src/byte_stuffed_frame_receiver_unit.sv
// byte_stuffed_frame_receiver_unit: top level, input register, result register
// depends on bsfr_pkg, bsfr_cfg and bsfr_core
//
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    rx_byte
// result    out        out_valid / out_ready  kind data is_pipe frame_length
//                                             block_done dropped_total good_messages
// config    in         cfg_write              cfg_index cfg_data
//
// one byte per cycle sustained while out_ready is high: a byte waits in the input
// register, and the state machine updates while it moves into the result register
// a result is offered once its byte has passed the input register into the result register;
// bytes with no result still take their slot
// out_ready low holds the result register, and the input register fills behind it
// reset clears the state, counters and valid flags and loads the register defaults
`default_nettype none

module byte_stuffed_frame_receiver_unit
    import bsfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             rx_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  kind,
    output logic [7:0]                  data,
    output logic                        is_pipe,
    output logic [LEN_W-1:0]            frame_length,
    output logic                        block_done,
    output logic [CNT32_W-1:0]          dropped_total,
    output logic [CNT32_W-1:0]          good_messages
);

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       advance;
    logic       res_valid;
    result_t    res;

    bsfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bsfr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // the held byte moves on once the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= res_valid;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign data          = out_reg.data;
    assign is_pipe       = out_reg.is_pipe;
    assign frame_length  = out_reg.frame_length;
    assign block_done    = out_reg.block_done;
    assign dropped_total = out_reg.dropped_total;
    assign good_messages = out_reg.good_messages;

endmodule

`default_nettype wire

>>> src/bsfr_checker.sv
// bsfr_checker: port-level assertions on the result channel of the receiver
// depends on bsfr_pkg; bound to byte_stuffed_frame_receiver_unit below
`default_nettype none

module bsfr_checker
    import bsfr_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [1:0]         kind,
    input wire logic [7:0]         data,
    input wire logic               is_pipe,
    input wire logic [LEN_W-1:0]   frame_length,
    input wire logic               block_done,
    input wire logic [CNT32_W-1:0] dropped_total,
    input wire logic [CNT32_W-1:0] good_messages
);

    // a stalled result transaction holds its kind, data, frame length and counters
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data) &&
        $stable(frame_length) && $stable(dropped_total) && $stable(good_messages))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_DATA) || (kind == KIND_GOOD) || (kind == KIND_ABORT))
        else $error("illegal result kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_GOOD) |-> (frame_length == '0) && !block_done)
        else $error("length or block flag on a result that is not a frame end");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_done |-> is_pipe)
        else $error("block done on a message frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_DATA) |-> (data == 8'd0))
        else $error("data byte on a frame end or abort");

endmodule

bind byte_stuffed_frame_receiver_unit bsfr_checker u_bsfr_checker (.*);

`default_nettype wire

>>> bench/tb_byte_stuffed_frame_receiver_unit.sv
`timescale 1ns / 100ps
// testbench for byte_stuffed_frame_receiver_unit: random and directed byte streams
// checked against a deframer model kept in a small scoreboard class
// depends on bsfr_pkg and the block's rtl
module tb_byte_stuffed_frame_receiver_unit;
    import bsfr_pkg::*;

    class deframer_model;
        cfg_t    regs;
        mode_t   rx_state;
        logic    on_pipe_path;
        logic [COUNT_W-1:0] body_count;
        logic [PKT_W-1:0]   pipe_frames;
        logic [CNT32_W-1:0] drop_count;
        logic [CNT32_W-1:0] msg_count;
        result_t frame_events[$];
        int      mismatches;

        function new();
            regs.start_byte        = RST_START_BYTE;
            regs.end_byte          = RST_END_BYTE;
            regs.escape_byte       = RST_ESCAPE_BYTE;
            regs.stuff_mask        = RST_STUFF_MASK;
            regs.pipe_type         = RST_PIPE_TYPE;
            regs.max_length        = RST_MAX_LENGTH;
            regs.packets_per_block = RST_PKTS_BLOCK;
            rx_state     = MODE_IDLE;
            on_pipe_path = 1'b0;
            body_count   = '0;
            pipe_frames  = '0;
            drop_count   = '0;
            msg_count    = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_START_BYTE:  regs.start_byte        = val[7:0];
                CFG_END_BYTE:    regs.end_byte          = val[7:0];
                CFG_ESCAPE_BYTE: regs.escape_byte       = val[7:0];
                CFG_STUFF_MASK:  regs.stuff_mask        = val[7:0];
                CFG_PIPE_TYPE:   regs.pipe_type         = val[7:0];
                CFG_MAX_LENGTH:  regs.max_length        = val[LEN_W-1:0];
                CFG_PKTS_BLOCK:  regs.packets_per_block = val[PKT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return frame_events.size();
        endfunction

        // one decoded body byte, or the overflow abort it causes
        function void store_body(logic [7:0] v, output result_t r);
            r = '0;
            body_count = body_count + 1'b1;
            if (body_count > {1'b0, regs.max_length})
            begin
                drop_count = drop_count + 1'b1;
                rx_state   = MODE_IDLE;
                body_count = '0;
                r.kind     = KIND_ABORT;
            end
            else
            begin
                rx_state = on_pipe_path ? MODE_PIPE : MODE_MSG;
                r.kind   = KIND_DATA;
                r.data   = v;
            end
        endfunction

        function void take_byte(logic [7:0] b);
            result_t r;
            bit      emits;
            r     = '0;
            emits = 1'b0;
            if (b == regs.start_byte)
            begin
                if (rx_state == MODE_MSG || rx_state == MODE_MSG_ESC ||
                    rx_state == MODE_PIPE || rx_state == MODE_PIPE_ESC)
                begin
                    r.kind = KIND_ABORT;
                    emits  = 1'b1;
                end
                rx_state   = MODE_TYPE;
                body_count = '0;
            end
            else
            begin
                case (rx_state)
                    MODE_TYPE:
                    begin
                        on_pipe_path = (b == regs.pipe_type);
                        rx_state     = on_pipe_path ? MODE_PIPE : MODE_MSG;
                        body_count   = COUNT_W'(1);
                        r.kind       = KIND_DATA;
                        r.data       = b;
                        emits        = 1'b1;
                    end
                    MODE_MSG, MODE_PIPE:
                    begin
                        if (b == regs.escape_byte)
                        begin
                            rx_state = on_pipe_path ? MODE_PIPE_ESC : MODE_MSG_ESC;
                        end
                        else if (b == regs.end_byte)
                        begin
                            r.kind         = KIND_GOOD;
                            r.frame_length = body_count[LEN_W-1:0];
                            if (on_pipe_path)
                            begin
                                pipe_frames = pipe_frames + 1'b1;
                                if (pipe_frames == regs.packets_per_block)
                                begin
                                    pipe_frames  = '0;
                                    r.block_done = 1'b1;
                                end
                            end
                            else
                            begin
                                msg_count = msg_count + 1'b1;
                            end
                            rx_state   = MODE_IDLE;
                            body_count = '0;
                            emits      = 1'b1;
                        end
                        else
                        begin
                            store_body(b, r);
                            emits = 1'b1;
                        end
                    end
                    MODE_MSG_ESC, MODE_PIPE_ESC:
                    begin
                        store_body(b ^ regs.stuff_mask, r);
                        emits = 1'b1;
                    end
                    default: rx_state = MODE_IDLE;
                endcase
            end
            if (emits)
            begin
                r.is_pipe       = on_pipe_path;
                r.dropped_total = drop_count;
                r.good_messages = msg_count;
                frame_events.push_back(r);
            end
        endfunction

        task report(string msg);
            if (mismatches < 100)
                $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [CNT32_W-1:0] got, logic [CNT32_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        endtask

        task check_event(result_t got);
            result_t want;
            if (frame_events.size() == 0)
            begin
                report("result transaction with no byte waiting for it");
                return;
            end
            want = frame_events.pop_front();
            check_field("kind", CNT32_W'(got.kind), CNT32_W'(want.kind));
            check_field("data", CNT32_W'(got.data), CNT32_W'(want.data));
            check_field("is_pipe", CNT32_W'(got.is_pipe), CNT32_W'(want.is_pipe));
            check_field("frame_length", CNT32_W'(got.frame_length),
                        CNT32_W'(want.frame_length));
            check_field("block_done", CNT32_W'(got.block_done), CNT32_W'(want.block_done));
            check_field("dropped_total", got.dropped_total, want.dropped_total);
            check_field("good_messages", got.good_messages, want.good_messages);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             rx_byte   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [1:0]             kind;
    logic [7:0]             data;
    logic                   is_pipe;
    logic [LEN_W-1:0]       frame_length;
    logic                   block_done;
    logic [CNT32_W-1:0]     dropped_total;
    logic [CNT32_W-1:0]     good_messages;

    deframer_model model = new();
    int in_idle_pct  = 12;
    int out_idle_pct = 45;
    int hold_left    = 0;
    int fed_count    = 0;

    byte_stuffed_frame_receiver_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .data          (data),
        .is_pipe       (is_pipe),
        .frame_length  (frame_length),
        .block_done    (block_done),
        .dropped_total (dropped_total),
        .good_messages (good_messages)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("byte_stuffed_frame_receiver_unit test failed");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        result_t got;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.kind          = kind_t'(kind);
                got.data          = data;
                got.is_pipe       = is_pipe;
                got.frame_length  = frame_length;
                got.block_done    = block_done;
                got.dropped_total = dropped_total;
                got.good_messages = good_messages;
                model.check_event(got);
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
            end
        end
    end

    task send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        model.take_byte(b);
        fed_count++;
    endtask

    // start, type byte, stuffed or random body, optional end flag
    task send_frame(input int body_n, input bit closed, input bit noisy);
        logic [7:0] t;
        logic [7:0] x;
        bit         placed;
        send_byte(model.regs.start_byte);
        if ($urandom_range(0, 1) == 1 && model.regs.pipe_type != model.regs.start_byte)
            t = model.regs.pipe_type;
        else
        begin
            t = 8'($urandom_range(0, 255));
            while (t == model.regs.start_byte)
                t = 8'($urandom_range(0, 255));
        end
        send_byte(t);
        for (int i = 0; i < body_n; i++)
        begin
            if (noisy)
                send_byte(8'($urandom_range(0, 255)));
            else
            begin
                placed = 1'b0;
                while (!placed)
                begin
                    x = 8'($urandom_range(0, 255));
                    if (x != model.regs.start_byte && x != model.regs.end_byte &&
                        x != model.regs.escape_byte)
                    begin
                        send_byte(x);
                        placed = 1'b1;
                    end
                    else if ((x ^ model.regs.stuff_mask) != model.regs.start_byte)
                    begin
                        send_byte(model.regs.escape_byte);
                        send_byte(x ^ model.regs.stuff_mask);
                        placed = 1'b1;
                    end
                end
            end
        end
        if (closed)
            send_byte(model.regs.end_byte);
    endtask

    task traffic(input int n);
        int goal;
        int pick;
        int lim;
        int len;
        goal = fed_count + n;
        while (fed_count < goal)
        begin
            pick = $urandom_range(0, 99);
            lim  = (model.regs.max_length + 2 < 48) ? model.regs.max_length + 2 : 48;
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lim) : $urandom_range(0, 6);
            if (pick < 78)
                send_frame(len, 1'b1, 1'b0);
            else if (pick < 88)
                send_frame(len, 1'b0, 1'b0);
            else if (pick < 94)
                send_frame(len, 1'b1, 1'b1);
            else
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // let in-flight bytes retire, including ones that give no result
    task settle();
        in_valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        model.write_reg(idx, val);
    endtask

    task load_regs(input cfg_t c);
        write_reg(CFG_START_BYTE, {8'h00, c.start_byte});
        write_reg(CFG_END_BYTE, {8'h00, c.end_byte});
        write_reg(CFG_ESCAPE_BYTE, {8'h00, c.escape_byte});
        write_reg(CFG_STUFF_MASK, {8'h00, c.stuff_mask});
        write_reg(CFG_PIPE_TYPE, {8'h00, c.pipe_type});
        write_reg(CFG_MAX_LENGTH, {4'h0, c.max_length});
        write_reg(CFG_PKTS_BLOCK, c.packets_per_block);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] directed_bytes[$];
        cfg_t       c;
        directed_bytes = '{
            8'h00, 8'hFF,                                  // outside a frame
            8'h7E, 8'h00, 8'h7C, 8'h5D, 8'hFF, 8'h7D,      // pipe frame, stuffed end flag
            8'h7E, 8'h7E, 8'hFF, 8'h00, 8'h7C, 8'h7D, 8'h7D, // restart, escaped end is data
            8'h7E, 8'h01, 8'hAA, 8'h7E, 8'h00, 8'h7D,      // start mid-frame aborts
            8'h7E, 8'h05, 8'h7C, 8'h7E, 8'h7C, 8'h7D       // start after escape aborts
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        settle();

        c = '{start_byte: 8'hFF, end_byte: 8'h00, escape_byte: 8'h80, stuff_mask: 8'hFF,
              pipe_type: 8'h55, max_length: 12'd4095, packets_per_block: 16'd1};
        load_regs(c);
        traffic(200);
        hold_left = 80;
        traffic(250);
        settle();

        in_idle_pct  = 45;
        out_idle_pct = 12;
        c = '{start_byte: 8'h00, end_byte: 8'hFF, escape_byte: 8'h01, stuff_mask: 8'h00,
              pipe_type: 8'hAA, max_length: 12'd12, packets_per_block: 16'd65535};
        load_regs(c);
        traffic(450);
        settle();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        c = '{start_byte: 8'h7E, end_byte: 8'h7D, escape_byte: 8'h7C, stuff_mask: 8'h20,
              pipe_type: 8'h00, max_length: 12'd1, packets_per_block: 16'd3};
        load_regs(c);
        traffic(200);
        settle();

        c.start_byte        = 8'($urandom_range(0, 255));
        c.end_byte          = 8'($urandom_range(0, 255));
        c.escape_byte       = 8'($urandom_range(0, 255));
        c.stuff_mask        = 8'($urandom_range(0, 255));
        c.pipe_type         = 8'($urandom_range(0, 255));
        c.max_length        = 12'($urandom_range(1, 40));
        c.packets_per_block = 16'($urandom_range(1, 6));
        load_regs(c);
        traffic(250);
        settle();

        repeat (8) @(posedge clk);
        if (model.mismatches == 0 && model.pending() == 0)
            $display("byte_stuffed_frame_receiver_unit test passed");
        else
            $display("byte_stuffed_frame_receiver_unit test failed");
        $finish;
    end

endmodule
